[design/assert_macros.svh]
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// general property, sampled on the rising edge, off while reset is held
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// plain invariant that must hold on every edge
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)

`endif

`endif

[design/pidc_pkg.sv]
`timescale 1ns / 1ps

package pidc_pkg;

  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned INTEG_W = 48;

  // serial multiplier: shifted operand, added operand, full product
  localparam int unsigned MUL_A_W = DATA_W;
  localparam int unsigned MUL_B_W = INTEG_W;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

endpackage

[design/pidc_mul.sv]
`timescale 1ns / 1ps

module pidc_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [pidc_pkg::MUL_A_W-1:0]  op_a,
  input  logic [pidc_pkg::MUL_B_W-1:0]  op_b,
  output logic [pidc_pkg::PROD_W-1:0]   product,
  output logic                          done
);
  import pidc_pkg::*;

  localparam int unsigned CNT_W = $clog2(MUL_A_W);

  logic [MUL_A_W-1:0] a_r;
  logic [MUL_B_W-1:0] b_r;
  logic [PROD_W-1:0]  acc_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic [MUL_B_W:0]   sum_nxt;

  // one bit of op_a per cycle, lsb first; partial sum enters at the top and shifts down
  assign sum_nxt = {1'b0, acc_r[PROD_W-1:MUL_A_W]} + (a_r[0] ? {1'b0, b_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(MUL_A_W - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= op_a;
      b_r   <= op_b;
      acc_r <= '0;
    end else if (busy_r) begin
      a_r   <= a_r >> 1;
      acc_r <= {sum_nxt, acc_r[MUL_A_W-1:1]};
    end
  end

  assign product = acc_r;
  assign done    = !busy_r;

endmodule

[design/pid_controller_step.sv]
// pid_controller_step: one q16.16 pid update per measurement or error transaction, worked out bit-serially
// such a transaction steps through err, start, pass one, term1, integ, start2, pass two, term2, sum and
// clamp; each pass is a shift-add multiply, the two in a row (the derivative divider runs one bit a cycle
// beside the first pass); in_ready is low until clamp loads the output; commands 2 and 3 return no result
// reset (rst_n low, synchronous): gains and setpoint to zero, bounds to -1.0 and +1.0,
// integral, last time and history cleared, no transaction pending
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pid_controller_step (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_command,
  input  logic signed [pidc_pkg::DATA_W-1:0]  in_sample,
  input  logic [31:0]                         in_now_time,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [pidc_pkg::DATA_W-1:0]  out_drive,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [2:0]                          cfg_index,
  input  logic [31:0]                         cfg_data
);
  import pidc_pkg::*;

  localparam logic [1:0] CMD_MEAS  = 2'd0;
  localparam logic [1:0] CMD_ERR   = 2'd1;
  localparam logic [1:0] CMD_RESET = 2'd2;

  localparam logic [2:0] REG_GAIN_P   = 3'd0;
  localparam logic [2:0] REG_GAIN_I   = 3'd1;
  localparam logic [2:0] REG_GAIN_D   = 3'd2;
  localparam logic [2:0] REG_SETPOINT = 3'd3;
  localparam logic [2:0] REG_OUT_LOW  = 3'd4;
  localparam logic [2:0] REG_OUT_HIGH = 3'd5;

  localparam logic signed [DATA_W-1:0] ONE_Q  = DATA_W'(1) << FRAC_W;
  localparam logic signed [DATA_W-1:0] D_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] D_MIN  = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [INTEG_W-1:0] I_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic signed [INTEG_W-1:0] I_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

  localparam int unsigned SHS_W     = PROD_W + 1 - FRAC_W;
  localparam int unsigned TERM_W    = 64;
  localparam int unsigned TERM_BITS = 61;
  localparam logic signed [SHS_W-1:0] TERM_HI =
    {{(SHS_W-TERM_BITS){1'b0}}, {TERM_BITS{1'b1}}};
  localparam logic signed [SHS_W-1:0] TERM_LO =
    {{(SHS_W-TERM_BITS){1'b1}}, {TERM_BITS{1'b0}}};

  localparam int unsigned INC_W      = INTEG_W + 1;
  localparam int unsigned ISUM_W     = INTEG_W + 2;
  localparam int unsigned DIV_STEPS  = DATA_W;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_ERR, S_START, S_PH1, S_TERM1, S_INTEG,
    S_START2, S_PH2, S_TERM2, S_SUM, S_CLAMP
  } state_t;

  function automatic logic [DATA_W-1:0] mag_d(input logic signed [DATA_W-1:0] v);
    return v[DATA_W-1] ? -v : v;
  endfunction

  function automatic logic [INTEG_W-1:0] mag_i(input logic signed [INTEG_W-1:0] v);
    return v[INTEG_W-1] ? -v : v;
  endfunction

  // signed floor(+-p / 2^frac)
  function automatic logic signed [SHS_W-1:0] shift_sign(input logic [PROD_W-1:0] p,
                                                         input logic neg);
    logic signed [PROD_W:0] s;
    s = $signed({1'b0, p});
    if (neg) begin
      s = -s;
    end
    return s[PROD_W:FRAC_W];
  endfunction

  function automatic logic signed [TERM_W-1:0] sat_term(input logic signed [SHS_W-1:0] v);
    logic signed [SHS_W-1:0] c;
    c = v;
    if (v > TERM_HI) begin
      c = TERM_HI;
    end else if (v < TERM_LO) begin
      c = TERM_LO;
    end
    return c[TERM_W-1:0];
  endfunction

  state_t state_r;

  logic signed [DATA_W-1:0]  gain_p_r, gain_i_r, gain_d_r, setpoint_r, out_low_r, out_high_r;
  logic signed [INTEG_W-1:0] integral_r;
  logic [31:0]               last_time_r;
  logic signed [DATA_W-1:0]  prev_pos_r, prev_err_r;

  logic [1:0]                cmd_r;
  logic signed [DATA_W-1:0]  sample_r;
  logic [31:0]               now_r;
  logic signed [DATA_W-1:0]  err_r;
  logic [31:0]               dt_r;
  logic                      first_r;

  logic [31:0]               rem_r, dlo_r;
  logic [DATA_W-1:0]         q_r;
  logic [DIV_CNT_W-1:0]      div_cnt_r;
  logic                      dneg_r, ovf_r;

  logic signed [INC_W-1:0]   inc_r;
  logic signed [DATA_W-1:0]  deriv_r;
  logic signed [TERM_W-1:0]  pterm_r, iterm_r, dterm_r, y_r;
  logic                      out_valid_r;
  logic signed [DATA_W-1:0]  out_drive_r;

  logic signed [DATA_W:0]    sp_diff, diff_nxt;
  logic [DATA_W:0]           md_nxt;
  logic signed [DATA_W-1:0]  err_nxt, deriv_nxt, drive_nxt;
  logic                      ovf_nxt;
  logic [32:0]               div_t;
  logic                      div_ge;
  logic [31:0]               rem_step;
  logic signed [SHS_W-1:0]   inc_full;
  logic signed [ISUM_W-1:0]  isum;
  logic signed [INTEG_W-1:0] integ_nxt;
  logic signed [TERM_W-1:0]  lo_ext, hi_ext;

  logic                      mul_start, mul_a_done, mul_b_done;
  logic [MUL_A_W-1:0]        op_a_a, op_a_b;
  logic [MUL_B_W-1:0]        op_b_a, op_b_b;
  logic [PROD_W-1:0]         prod_a, prod_b;

  // pass one: dt * |err| and |kp| * |err|; pass two: |ki| * |integral| and |kd| * |deriv|
  assign mul_start = (state_r == S_START) || (state_r == S_START2);
  assign op_a_a = (state_r == S_START) ? dt_r : mag_d(gain_i_r);
  assign op_b_a = (state_r == S_START) ? MUL_B_W'(mag_d(err_r)) : mag_i(integral_r);
  assign op_a_b = (state_r == S_START) ? mag_d(gain_p_r) : mag_d(gain_d_r);
  assign op_b_b = (state_r == S_START) ? MUL_B_W'(mag_d(err_r)) : MUL_B_W'(mag_d(deriv_r));

  pidc_mul u_mul_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .op_a    (op_a_a),
    .op_b    (op_b_a),
    .product (prod_a),
    .done    (mul_a_done)
  );

  pidc_mul u_mul_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .op_a    (op_a_b),
    .op_b    (op_b_b),
    .product (prod_b),
    .done    (mul_b_done)
  );

  always_comb begin
    sp_diff = {setpoint_r[DATA_W-1], setpoint_r} - {sample_r[DATA_W-1], sample_r};
    if (sp_diff[DATA_W] != sp_diff[DATA_W-1]) begin
      err_nxt = sp_diff[DATA_W] ? D_MIN : D_MAX;
    end else begin
      err_nxt = sp_diff[DATA_W-1:0];
    end
    if (cmd_r != CMD_MEAS) begin
      err_nxt = sample_r;
    end
  end

  always_comb begin
    if (cmd_r == CMD_MEAS) begin
      diff_nxt = {sample_r[DATA_W-1], sample_r} - {prev_pos_r[DATA_W-1], prev_pos_r};
    end else begin
      diff_nxt = {err_r[DATA_W-1], err_r} - {prev_err_r[DATA_W-1], prev_err_r};
    end
    md_nxt  = diff_nxt[DATA_W] ? -diff_nxt : diff_nxt;
    // quotient of (md << 16) / dt reaches 2^32 exactly when md >> 16 >= dt
    ovf_nxt = {15'd0, md_nxt[DATA_W:FRAC_W]} >= dt_r;
  end

  // restoring division, one quotient bit a cycle; remainder stays below dt when no overflow is flagged
  assign div_t    = {rem_r, dlo_r[31]};
  assign div_ge   = div_t >= {1'b0, dt_r};
  assign rem_step = div_ge ? 32'(div_t - {1'b0, dt_r}) : div_t[31:0];

  always_comb begin
    if (first_r || dt_r == '0) begin
      deriv_nxt = '0;
    end else if (ovf_r) begin
      deriv_nxt = dneg_r ? D_MIN : D_MAX;
    end else if (!dneg_r) begin
      deriv_nxt = q_r[DATA_W-1] ? D_MAX : q_r;
    end else if (q_r[DATA_W-1] && q_r[DATA_W-2:0] != '0) begin
      deriv_nxt = D_MIN;
    end else begin
      deriv_nxt = -q_r;
    end
  end

  assign inc_full = shift_sign(prod_a, err_r[DATA_W-1]);

  always_comb begin
    isum = {{2{integral_r[INTEG_W-1]}}, integral_r} + {inc_r[INC_W-1], inc_r};
    if (isum[ISUM_W-1:INTEG_W-1] != '0 && isum[ISUM_W-1:INTEG_W-1] != '1) begin
      integ_nxt = isum[ISUM_W-1] ? I_MIN : I_MAX;
    end else begin
      integ_nxt = isum[INTEG_W-1:0];
    end
  end

  always_comb begin
    lo_ext = {{(TERM_W-DATA_W){out_low_r[DATA_W-1]}}, out_low_r};
    hi_ext = {{(TERM_W-DATA_W){out_high_r[DATA_W-1]}}, out_high_r};
    if (y_r < lo_ext) begin
      drive_nxt = out_low_r;
    end else if (y_r > hi_ext) begin
      drive_nxt = out_high_r;
    end else begin
      drive_nxt = y_r[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      gain_p_r    <= '0;
      gain_i_r    <= '0;
      gain_d_r    <= '0;
      setpoint_r  <= '0;
      out_low_r   <= -ONE_Q;
      out_high_r  <= ONE_Q;
      integral_r  <= '0;
      last_time_r <= '0;
      prev_pos_r  <= '0;
      prev_err_r  <= '0;
      div_cnt_r   <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_GAIN_P:   gain_p_r   <= cfg_data;
          REG_GAIN_I:   gain_i_r   <= cfg_data;
          REG_GAIN_D:   gain_d_r   <= cfg_data;
          REG_SETPOINT: setpoint_r <= cfg_data;
          REG_OUT_LOW:  out_low_r  <= cfg_data;
          REG_OUT_HIGH: out_high_r <= cfg_data;
          default: ;
        endcase
      end

      // the clamp state reloads the output register itself
      if (out_valid_r && out_ready && state_r != S_CLAMP) begin
        out_valid_r <= 1'b0;
      end

      if (div_cnt_r != '0) begin
        rem_r     <= rem_step;
        dlo_r     <= dlo_r << 1;
        q_r       <= {q_r[DATA_W-2:0], div_ge};
        div_cnt_r <= div_cnt_r - 1'b1;
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r    <= in_command;
            sample_r <= in_sample;
            now_r    <= in_now_time;
            if (in_command == CMD_RESET) begin
              integral_r  <= '0;
              prev_pos_r  <= in_sample;
              last_time_r <= '0;
            end else if (in_command == CMD_MEAS || in_command == CMD_ERR) begin
              state_r <= S_ERR;
            end
          end
        end
        S_ERR: begin
          err_r   <= err_nxt;
          dt_r    <= now_r - last_time_r;
          first_r <= (last_time_r == '0);
          state_r <= S_START;
        end
        S_START: begin
          dneg_r    <= diff_nxt[DATA_W];
          ovf_r     <= ovf_nxt;
          rem_r     <= {15'd0, md_nxt[DATA_W:FRAC_W]};
          dlo_r     <= {md_nxt[FRAC_W-1:0], {FRAC_W{1'b0}}};
          div_cnt_r <= DIV_CNT_W'(DIV_STEPS);
          state_r   <= S_PH1;
        end
        S_PH1: begin
          if (mul_a_done && mul_b_done && div_cnt_r == '0) begin
            state_r <= S_TERM1;
          end
        end
        S_TERM1: begin
          inc_r   <= inc_full[INC_W-1:0];
          deriv_r <= deriv_nxt;
          pterm_r <= sat_term(shift_sign(prod_b, gain_p_r[DATA_W-1] ^ err_r[DATA_W-1]));
          state_r <= S_INTEG;
        end
        S_INTEG: begin
          if (!first_r) begin
            integral_r <= integ_nxt;
          end
          last_time_r <= now_r;
          if (cmd_r == CMD_MEAS) begin
            prev_pos_r <= sample_r;
          end else begin
            prev_err_r <= err_r;
          end
          state_r <= S_START2;
        end
        S_START2: begin
          state_r <= S_PH2;
        end
        S_PH2: begin
          if (mul_a_done && mul_b_done) begin
            state_r <= S_TERM2;
          end
        end
        S_TERM2: begin
          iterm_r <= sat_term(shift_sign(prod_a, gain_i_r[DATA_W-1] ^ integral_r[INTEG_W-1]));
          dterm_r <= sat_term(shift_sign(prod_b, gain_d_r[DATA_W-1] ^ deriv_r[DATA_W-1]));
          state_r <= S_SUM;
        end
        S_SUM: begin
          y_r     <= pterm_r + iterm_r + dterm_r;
          state_r <= S_CLAMP;
        end
        S_CLAMP: begin
          // hold the result here until the output register is free
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_drive_r <= drive_nxt;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_drive = out_drive_r;

  `ASSERT_ALWAYS(a_mul_lockstep, clk, rst_n, mul_a_done == mul_b_done, "multipliers out of step")

  `ASSERT_PROP(a_div_in_time, clk, rst_n, (state_r == S_PH1) && mul_a_done |-> div_cnt_r == '0, "divider still busy after multiply pass")

  `ASSERT_PROP(a_clamp_bounds, clk, rst_n, (state_r == S_CLAMP) && (!out_valid_r || out_ready) && (out_low_r <= out_high_r) |=> (out_drive_r >= $past(out_low_r)) && (out_drive_r <= $past(out_high_r)), "drive outside bounds")

  `ASSERT_PROP(a_reset_cmd, clk, rst_n, in_valid && in_ready && (in_command == CMD_RESET) |=> (state_r == S_IDLE) && (last_time_r == '0), "reset command did not return to idle")

endmodule
